/* rtl/core/fspt_pkg.sv */
// Package for the fee sorted pool table: field widths, codes and reset values.
// Used by every module of the block; depends on nothing.
package fspt_pkg;
  localparam int DepthDefault = 32;
  localparam int KeyW = 64;
  localparam int FeeW = 48;
  localparam int SizeW = 21;
  localparam int BytesW = 32;
  localparam int SumW = 53;
  localparam int ProdW = FeeW + SizeW;
  localparam logic [BytesW-1:0] CapReset = 32'd314572800;
  localparam logic [FeeW-1:0] MinFeeReset = 48'd1000;
  localparam logic [SizeW-1:0] SmallSize = 21'd100;

  localparam logic [2:0] OpInsert = 3'd0;
  localparam logic [2:0] OpRemove = 3'd1;
  localparam logic [2:0] OpLookup = 3'd2;
  localparam logic [2:0] OpSelect = 3'd3;
  localparam logic [2:0] OpEvict = 3'd4;
  localparam logic [2:0] OpClear = 3'd5;

  localparam logic [2:0] StOk = 3'd0;
  localparam logic [2:0] StExists = 3'd1;
  localparam logic [2:0] StFeeLow = 3'd2;
  localparam logic [2:0] StNoSpace = 3'd3;
  localparam logic [2:0] StFull = 3'd4;
  localparam logic [2:0] StNotFound = 3'd5;
  localparam logic [2:0] StEvicted = 3'd6;
  localparam logic [2:0] StSelected = 3'd7;

  localparam logic CfgCapacity = 1'b0;
  localparam logic CfgMinFee = 1'b1;

  typedef struct packed {
    logic [KeyW-1:0] key;
    logic [FeeW-1:0] fee;
    logic [SizeW-1:0] size;
  } entry_t;

  // Per-cycle command broadcast to every cell of the chain.
  typedef struct packed {
    logic shift_up;   // cell i loads from cell i+1 when at or above the hole
    logic insert;     // open a gap and place the new entry
    logic [5:0] pos;  // hole or insertion position
    entry_t ent;
  } cell_cmd_t;
endpackage

/* rtl/core/fspt_cell.sv */
// One slot of the sorted chain: holds an entry and shifts to either neighbor.
// Depends on fspt_pkg.
module fspt_cell #(
  parameter int Idx = 0
) (
  input  logic               clk,
  input  fspt_pkg::cell_cmd_t cmd,
  input  fspt_pkg::entry_t   from_lo,
  input  fspt_pkg::entry_t   from_hi,
  output fspt_pkg::entry_t   ent
);
  localparam logic [5:0] MyIdx = 6'(Idx);

  always_ff @(posedge clk) begin
    if (cmd.insert) begin
      if (MyIdx == cmd.pos) begin
        ent <= cmd.ent;
      end else if (MyIdx > cmd.pos) begin
        ent <= from_lo;
      end
    end else if (cmd.shift_up && MyIdx >= cmd.pos) begin
      ent <= from_hi;
    end
  end
endmodule

/* rtl/core/fspt_chain.sv */
// Row of slot cells wired as a shift chain with an indexed read tap.
// Depends on fspt_pkg and fspt_cell.
module fspt_chain #(
  parameter int Depth = fspt_pkg::DepthDefault
) (
  input  logic                clk,
  input  fspt_pkg::cell_cmd_t cmd,
  input  logic [5:0]          rd_idx,
  output fspt_pkg::entry_t    rd_ent
);
  fspt_pkg::entry_t ents [Depth];

  for (genvar i = 0; i < Depth; i++) begin : g_cell
    fspt_pkg::entry_t lo, hi;
    if (i == 0) begin : g_lo0
      assign lo = '0;
    end else begin : g_lo
      assign lo = ents[i-1];
    end
    if (i == Depth - 1) begin : g_hiN
      assign hi = '0;
    end else begin : g_hi
      assign hi = ents[i+1];
    end
    fspt_cell #(.Idx(i)) u_cell (
      .clk(clk), .cmd(cmd), .from_lo(lo), .from_hi(hi), .ent(ents[i])
    );
  end

  always_comb begin
    rd_ent = '0;
    for (int i = 0; i < Depth; i++) begin
      if (rd_idx == 6'(i)) rd_ent = ents[i];
    end
  end
endmodule

/* rtl/core/fee_sorted_pool_table_top.sv */
// Top level of the fee sorted pool table: sequencer, totals and result register.
// Depends on fspt_pkg and fspt_chain.
//
//  channel | direction | handshake     | payload
//  in      | input     | valid / stall | opcode key fee size budget
//  out     | output    | valid / stall | status entry_* pool_* batch_* last
//  cfg     | input     | valid / ready | index data
//
// One item is worked on at a time. The sequencer walks the chain one slot at a
// time through the single read tap. An insert takes a key scan step and a rate
// scan step per slot, with one 48x21 product pair per slot, plus a step per eviction.
// Each result waits in the output register; steps that emit a result hold while it is stalled.
// Reset (rst, synchronous) empties the pool and restores both registers.
module fee_sorted_pool_table_top #(
  parameter int Depth = fspt_pkg::DepthDefault
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [2:0]  opcode,
  input  logic [63:0] key,
  input  logic [47:0] fee,
  input  logic [20:0] size,
  input  logic [31:0] budget,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [2:0]  status,
  output logic        entry_valid,
  output logic [63:0] entry_key,
  output logic [47:0] entry_fee,
  output logic [20:0] entry_size,
  output logic [5:0]  pool_count,
  output logic [31:0] pool_bytes,
  output logic [52:0] pool_fees,
  output logic [5:0]  batch_count,
  output logic [52:0] batch_fees,
  output logic        last,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic        cfg_index,
  input  logic [47:0] cfg_data
);
  localparam logic [5:0] DepthC = 6'(Depth);

  typedef enum logic [3:0] {
    S_IDLE, S_FIND, S_FIND_RD, S_DECIDE, S_EVICT, S_EVICT_SHIFT, S_POS, S_POS_MUL,
    S_POS_CMP, S_PLACE, S_SEL, S_SEL_RD, S_DONE
  } state_t;

  state_t state;
  logic [31:0] capacity;
  logic [47:0] min_fee_r;
  logic [2:0] op;
  fspt_pkg::entry_t cur;
  logic [31:0] bud;
  logic [5:0] total, idx, cnt;
  logic [31:0] byte_tot;
  logic [52:0] fee_tot, bf;
  logic [32:0] freed, taken;
  logic [68:0] p_slot, p_new;
  logic found;
  logic [2:0] fin_st;

  fspt_pkg::cell_cmd_t cmd;
  fspt_pkg::entry_t rd;
  logic [5:0] rd_idx;

  fspt_chain #(.Depth(Depth)) u_chain (.clk(clk), .cmd(cmd), .rd_idx(rd_idx), .rd_ent(rd));

  assign cfg_ready = 1'b1;
  assign in_stall = (state != S_IDLE) || out_valid;
  wire out_free = !out_valid || !out_stall;
  wire [32:0] after_size = {1'b0, byte_tot} + 33'(cur.size);
  wire [32:0] take_next = taken + 33'(rd.size);

  always_comb begin
    cmd = '0;
    cmd.ent = cur;
    cmd.pos = idx;
    rd_idx = idx;
    if (state == S_PLACE) cmd.insert = 1'b1;
    if (state == S_EVICT_SHIFT && op == fspt_pkg::OpRemove) cmd.shift_up = 1'b1;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      out_valid <= 1'b0;
      capacity <= fspt_pkg::CapReset;
      min_fee_r <= fspt_pkg::MinFeeReset;
      total <= '0;
      byte_tot <= '0;
      fee_tot <= '0;
    end else begin
      if (cfg_valid) begin
        if (cfg_index == fspt_pkg::CfgCapacity) capacity <= cfg_data[31:0];
        else min_fee_r <= cfg_data;
      end
      if (out_valid && !out_stall) out_valid <= 1'b0;
      case (state)
        S_IDLE: begin
          if (in_valid && !in_stall) begin
            op <= opcode;
            cur <= '{key: key, fee: fee, size: size};
            bud <= budget;
            idx <= '0;
            cnt <= '0;
            bf <= '0;
            freed <= '0;
            taken <= '0;
            found <= 1'b0;
            case (opcode)
              fspt_pkg::OpInsert, fspt_pkg::OpRemove, fspt_pkg::OpLookup: state <= S_FIND;
              fspt_pkg::OpSelect: begin
                fin_st <= fspt_pkg::StOk;
                state <= S_SEL;
              end
              fspt_pkg::OpEvict: state <= S_EVICT;
              fspt_pkg::OpClear: begin
                total <= '0;
                byte_tot <= '0;
                fee_tot <= '0;
                fin_st <= fspt_pkg::StOk;
                state <= S_DONE;
              end
              default: begin
                fin_st <= fspt_pkg::StOk;
                state <= S_DONE;
              end
            endcase
          end
        end
        S_FIND: begin
          if (idx >= total) state <= S_DECIDE;
          else state <= S_FIND_RD;
        end
        S_FIND_RD: begin
          if (rd.key == cur.key) begin
            found <= 1'b1;
            state <= S_DECIDE;
          end else begin
            idx <= idx + 6'd1;
            state <= S_FIND;
          end
        end
        S_DECIDE: begin
          if (out_free) begin
            if (op == fspt_pkg::OpInsert) begin
              if (found) begin
                cur <= rd;
                fin_st <= fspt_pkg::StExists;
                state <= S_DONE;
              end else if (cur.fee < min_fee_r && cur.size > fspt_pkg::SmallSize) begin
                fin_st <= fspt_pkg::StFeeLow;
                state <= S_DONE;
              end else if (after_size > {1'b0, capacity}) begin
                state <= S_EVICT;
              end else begin
                idx <= '0;
                state <= (total >= DepthC) ? S_DONE : S_POS;
                fin_st <= fspt_pkg::StFull;
              end
            end else if (!found) begin
              fin_st <= fspt_pkg::StNotFound;
              state <= S_DONE;
            end else begin
              cur <= rd;
              fin_st <= fspt_pkg::StOk;
              if (op == fspt_pkg::OpRemove) begin
                total <= total - 6'd1;
                byte_tot <= byte_tot - 32'(rd.size);
                fee_tot <= fee_tot - 53'(rd.fee);
                state <= S_EVICT_SHIFT;
              end else begin
                state <= S_DONE;
              end
            end
          end
        end
        S_EVICT_SHIFT: state <= S_DONE;
        S_EVICT: begin
          // Read tap points at the last slot; eviction needs no shift.
          idx <= total - 6'd1;
          if (out_free) begin
            if (total != '0 && freed < 33'(cur.size) && idx == total - 6'd1) begin
              freed <= freed + 33'(rd.size);
              total <= total - 6'd1;
              byte_tot <= byte_tot - 32'(rd.size);
              fee_tot <= fee_tot - 53'(rd.fee);
              cnt <= cnt + 6'd1;
              out_valid <= 1'b1;
              status <= fspt_pkg::StEvicted;
              entry_valid <= 1'b1;
              {entry_key, entry_fee, entry_size} <= rd;
              pool_count <= total - 6'd1;
              pool_bytes <= byte_tot - 32'(rd.size);
              pool_fees <= fee_tot - 53'(rd.fee);
              batch_count <= cnt + 6'd1;
              batch_fees <= '0;
              last <= 1'b0;
            end else if (total == '0 || freed >= 33'(cur.size)) begin
              if (freed < 33'(cur.size)) begin
                fin_st <= fspt_pkg::StNoSpace;
                state <= S_DONE;
              end else if (op == fspt_pkg::OpEvict) begin
                fin_st <= fspt_pkg::StOk;
                state <= S_DONE;
              end else begin
                idx <= '0;
                fin_st <= fspt_pkg::StFull;
                state <= (total >= DepthC) ? S_DONE : S_POS;
              end
            end
          end
        end
        S_POS: state <= (idx >= total) ? S_PLACE : S_POS_MUL;
        S_POS_MUL: begin
          p_slot <= 69'(rd.fee) * 69'(cur.size);
          p_new <= 69'(cur.fee) * 69'(rd.size);
          state <= S_POS_CMP;
        end
        S_POS_CMP: begin
          if (p_slot >= p_new) begin
            idx <= idx + 6'd1;
            state <= S_POS;
          end else begin
            state <= S_PLACE;
          end
        end
        S_PLACE: begin
          total <= total + 6'd1;
          byte_tot <= byte_tot + 32'(cur.size);
          fee_tot <= fee_tot + 53'(cur.fee);
          fin_st <= fspt_pkg::StOk;
          found <= 1'b1;
          state <= S_DONE;
        end
        S_SEL: state <= (idx >= total || taken >= {1'b0, bud}) ? S_DONE : S_SEL_RD;
        S_SEL_RD: begin
          fin_st <= fspt_pkg::StOk;
          if (take_next > {1'b0, bud}) begin
            idx <= idx + 6'd1;
            state <= S_SEL;
          end else if (out_free) begin
            taken <= take_next;
            bf <= bf + 53'(rd.fee);
            cnt <= cnt + 6'd1;
            idx <= idx + 6'd1;
            out_valid <= 1'b1;
            status <= fspt_pkg::StSelected;
            entry_valid <= 1'b1;
            {entry_key, entry_fee, entry_size} <= rd;
            pool_count <= total;
            pool_bytes <= byte_tot;
            pool_fees <= fee_tot;
            batch_count <= cnt + 6'd1;
            batch_fees <= bf + 53'(rd.fee);
            last <= 1'b0;
            state <= S_SEL;
          end
        end
        S_DONE: begin
          if (out_free) begin
            // Entry fields are shown for lookups, removes, duplicates and placements.
            logic show;
            show = (fin_st == fspt_pkg::StExists) ||
                   (fin_st == fspt_pkg::StOk && found &&
                    (op == fspt_pkg::OpInsert || op == fspt_pkg::OpRemove ||
                     op == fspt_pkg::OpLookup));
            out_valid <= 1'b1;
            status <= fin_st;
            entry_valid <= show;
            entry_key <= show ? cur.key : '0;
            entry_fee <= show ? cur.fee : '0;
            entry_size <= show ? cur.size : '0;
            pool_count <= total;
            pool_bytes <= byte_tot;
            pool_fees <= fee_tot;
            batch_count <= cnt;
            batch_fees <= (op == fspt_pkg::OpSelect) ? bf : '0;
            last <= 1'b1;
            state <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end
endmodule

/* rtl/core/fspt_checker.sv */
// Port-level checks for the fee sorted pool table, bound to the top level.
// Depends on fee_sorted_pool_table_top's ports and fspt_pkg.
module fspt_checker (
  input logic clk,
  input logic rst,
  input logic in_valid,
  input logic in_stall,
  input logic out_valid,
  input logic out_stall,
  input logic [2:0] status,
  input logic entry_valid,
  input logic [63:0] entry_key,
  input logic last
);
  a_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(entry_key) && $stable(status))
    else $error("stalled item changed");
  a_idle_ready: assert property (@(posedge clk) disable iff (rst)
    in_valid && !in_stall |=> in_stall)
    else $error("second item accepted while busy");
  a_entry_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && !entry_valid |-> entry_key == 64'd0)
    else $error("entry fields not cleared");
  a_mid_status: assert property (@(posedge clk) disable iff (rst)
    out_valid && !last |-> status == fspt_pkg::StEvicted || status == fspt_pkg::StSelected)
    else $error("intermediate item with final status");
endmodule

bind fee_sorted_pool_table_top fspt_checker u_fspt_checker (
  .clk(clk), .rst(rst), .in_valid(in_valid), .in_stall(in_stall),
  .out_valid(out_valid), .out_stall(out_stall), .status(status),
  .entry_valid(entry_valid), .entry_key(entry_key), .last(last)
);
